[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)

`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

[rtl/b2da_pkg.sv]
// ---------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b2da_pkg;

  localparam int VALUE_W    = 16;
  localparam int NUM_DIGITS = 5;   // decimal digits of the largest VALUE_W-bit value
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int CNT_W      = $clog2(VALUE_W);
  localparam int PTR_W      = $clog2(NUM_DIGITS);
  localparam int CHAR_W     = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               mode;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic shift;
    logic pick;
    logic emit;
  } b2da_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic shift_last;
    logic ptr_zero;
    logic out_free;
  } b2da_sts_t;

endpackage

`default_nettype wire

[rtl/binary_to_decimal_ascii.sv]
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii
// Unsigned binary to decimal ASCII digit stream, most significant first.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_item carries a 16-bit value and a mode
//   bit. Mode 0 drops leading zeros (zero gives one '0'); mode 1 always gives
//   five zero-padded digits. Each digit leaves on out_valid/out_stall/out_item
//   as an ASCII code, with last set on the units digit.
//   Conversion is double dabble: one value bit per cycle through all 16
//   value bits, then a pick state finds the first digit. The first digit
//   leaves after the shifts and the pick; the rest follow one per cycle
//   while the output is not stalled. An item occupies the block through
//   the shifts, the pick and one emit per digit; in_stall stays high from
//   the accept until the last digit is loaded into the output register.
//   Output is one register: a stalled digit holds and the sequencer waits.
//   Synchronous reset empties the output register and returns to idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module binary_to_decimal_ascii (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire b2da_pkg::in_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output b2da_pkg::out_item_t     out_item
);

  b2da_pkg::b2da_cmd_t cmd;
  b2da_pkg::b2da_sts_t sts;

  b2da_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  b2da_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  `ASSERT_PROP(a_busy_after_accept, clk, rst_n, (in_valid && !in_stall) |=> in_stall, "accepted item did not block the input")

  `ASSERT_NEVER(a_digit_range, clk, rst_n, out_valid && ((out_item.digit_char < b2da_pkg::ASCII_ZERO) || (out_item.digit_char > (b2da_pkg::ASCII_ZERO + 6'd9))), "digit character outside 0..9")

  `ASSERT_PROP(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_item)), "stalled item changed")

  `ASSERT_NEVER(a_no_emit_while_busy_in, clk, rst_n, out_valid && !in_stall && !out_item.last, "input reopened before last digit")

endmodule

`default_nettype wire

[rtl/b2da_dp.sv]
// ---------------------------------------------------------------------------
// b2da_dp
// Double-dabble shift register, digit pointer and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b2da_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire b2da_pkg::in_item_t  in_item,
  input  wire b2da_pkg::b2da_cmd_t cmd,
  output b2da_pkg::b2da_sts_t      sts,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output b2da_pkg::out_item_t      out_item
);

  logic [b2da_pkg::VALUE_W-1:0] bin_r;
  logic [b2da_pkg::BCD_W-1:0]   bcd_r;
  logic [b2da_pkg::BCD_W-1:0]   bcd_adj;
  logic                         mode_r;
  logic [b2da_pkg::CNT_W-1:0]   cnt_r;
  logic [b2da_pkg::PTR_W-1:0]   ptr_r;
  logic [b2da_pkg::PTR_W-1:0]   lead_idx;
  logic [3:0]                   dig [b2da_pkg::NUM_DIGITS];
  logic                         out_valid_r;
  b2da_pkg::out_item_t          out_item_r;

  always_comb begin
    for (int i = 0; i < b2da_pkg::NUM_DIGITS; i++) begin
      dig[i] = bcd_r[4*i +: 4];
    end
  end

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < b2da_pkg::NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (dig[i] >= 4'd5) ? dig[i] + 4'd3 : dig[i];
    end
  end

  // highest nonzero digit; zero value falls back to the units digit
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < b2da_pkg::NUM_DIGITS; i++) begin
      if (dig[i] != 4'd0) begin
        lead_idx = b2da_pkg::PTR_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r  <= in_item.value;
      bcd_r  <= '0;
      mode_r <= in_item.mode;
      cnt_r  <= '0;
    end else if (cmd.shift) begin
      {bcd_r, bin_r} <= {bcd_adj[b2da_pkg::BCD_W-2:0], bin_r, 1'b0};
      cnt_r          <= cnt_r + 1'b1;
    end
    if (cmd.pick) begin
      ptr_r <= mode_r ? b2da_pkg::PTR_W'(b2da_pkg::NUM_DIGITS - 1) : lead_idx;
    end else if (cmd.emit) begin
      ptr_r <= ptr_r - 1'b1;
    end
    if (cmd.emit) begin
      out_item_r.digit_char <= b2da_pkg::ASCII_ZERO + {2'b00, dig[ptr_r]};
      out_item_r.last       <= (ptr_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.shift_last = (cnt_r == b2da_pkg::CNT_W'(b2da_pkg::VALUE_W - 1));
  assign sts.ptr_zero   = (ptr_r == '0);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

[rtl/b2da_ctrl.sv]
// ---------------------------------------------------------------------------
// b2da_ctrl
// Sequencer: load, shift through all value bits, pick first digit, emit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b2da_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire b2da_pkg::b2da_sts_t sts,
  output b2da_pkg::b2da_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_PICK,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        cmd.shift = 1'b1;
        if (sts.shift_last) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.ptr_zero) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

`default_nettype wire

[dv/binary_to_decimal_ascii_tb.sv]
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii_tb
// Self-checking bench for the binary to decimal ASCII converter.
// Values and mode bits go in through a driver fed from a queue of pending
// items. Each accepted value is turned into its expected digit stream, and a
// monitor checks every digit that leaves, character and last flag. Both sides
// idle at random, the receiver holds off once for a long stretch, and the
// sender drains the block completely at a few points.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_to_decimal_ascii_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned MAX_IDLE    = 13;

  typedef struct {
    b2da_pkg::in_item_t item;
    int unsigned        gap;    // idle cycles before this item is offered
    bit                 drain;  // wait for every digit before offering
  } offer_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  b2da_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  b2da_pkg::out_item_t out_item;

  offer_t              pending[$];
  b2da_pkg::out_item_t digits_due[$];
  int unsigned digits_queued  = 0;
  int unsigned digits_checked = 0;
  int unsigned errors         = 0;
  int unsigned cycles         = 0;
  int unsigned hold_requests  = 0;
  int unsigned holds_done     = 0;
  bit          calm_rx        = 1'b0;

  binary_to_decimal_ascii dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #10 clk = ~clk;

  // Decimal digits of one value, most significant first.
  task automatic push_decimal_digits(input b2da_pkg::in_item_t it);
    int unsigned         rest;
    int unsigned         place;
    int unsigned         n;
    int unsigned         d;
    b2da_pkg::out_item_t dig;
    rest  = it.value;
    n     = 1;
    place = 1;
    while ((it.mode && n < b2da_pkg::NUM_DIGITS) || (!it.mode && rest / place >= 10)) begin
      place = place * 10;
      n++;
    end
    for (int unsigned k = 0; k < n; k++) begin
      d              = rest / place;
      rest           = rest - d * place;
      dig.digit_char = b2da_pkg::CHAR_W'(b2da_pkg::ASCII_ZERO + d);
      dig.last       = (k == n - 1);
      digits_due.push_back(dig);
      digits_queued++;
      place = place / 10;
    end
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic add_item(input logic [b2da_pkg::VALUE_W-1:0] value, input logic mode,
                          input int unsigned gap, input bit drain);
    offer_t o;
    o.item.value = value;
    o.item.mode  = mode;
    o.gap        = gap;
    o.drain      = drain;
    pending.push_back(o);
  endtask

  // Driver
  always @(posedge clk) begin
    int unsigned idle_left;
    logic        next_valid;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      idle_left = 0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        push_decimal_digits(in_item);
        void'(pending.pop_front());
        next_valid = 1'b0;
        idle_left  = (pending.size() != 0) ? pending[0].gap : 0;
      end
      if (!next_valid && pending.size() != 0) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (!pending[0].drain || digits_queued == digits_checked) begin
          next_valid = 1'b1;
          in_item    <= pending[0].item;
        end
      end
      in_valid <= next_valid;
    end
  end

  // Monitor and receiver stall
  always @(posedge clk) begin
    int unsigned         stall_left;
    b2da_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        digits_checked <= digits_checked + 1;
        if (digits_due.size() == 0) begin
          report_mismatch($sformatf("digit 0x%0h with nothing expected",
                                    out_item.digit_char));
        end else begin
          want = digits_due.pop_front();
          if (out_item.digit_char !== want.digit_char)
            report_mismatch($sformatf("digit_char 0x%0h, expected 0x%0h",
                                      out_item.digit_char, want.digit_char));
          if (out_item.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b on digit 0x%0h",
                                      out_item.last, want.last, want.digit_char));
        end
        stall_left = calm_rx ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (hold_requests != holds_done) begin
        stall_left = LONG_HOLD;
        holds_done++;
      end
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned top;
    int unsigned gap;

    // Directed: zero, full scale, digit-count boundaries, bit patterns
    add_item(16'd0,     1'b0, 0, 1'b0);
    add_item(16'd0,     1'b1, 0, 1'b0);
    add_item(16'hFFFF,  1'b0, 3, 1'b0);
    add_item(16'hFFFF,  1'b1, 0, 1'b0);
    add_item(16'd1,     1'b0, 0, 1'b0);
    add_item(16'd1,     1'b1, 5, 1'b0);
    add_item(16'd9,     1'b0, 0, 1'b0);
    add_item(16'd10,    1'b0, 0, 1'b0);
    add_item(16'd99,    1'b0, 1, 1'b0);
    add_item(16'd100,   1'b0, 0, 1'b0);
    add_item(16'd999,   1'b0, 0, 1'b0);
    add_item(16'd1000,  1'b0, 7, 1'b0);
    add_item(16'd9999,  1'b0, 0, 1'b0);
    add_item(16'd10000, 1'b0, 0, 1'b0);
    add_item(16'd10000, 1'b1, 0, 1'b0);
    add_item(16'd59999, 1'b0, 2, 1'b0);
    add_item(16'd60000, 1'b1, 0, 1'b0);
    add_item(16'h8000,  1'b0, 0, 1'b0);
    add_item(16'h5555,  1'b1, 0, 1'b0);
    add_item(16'hAAAA,  1'b0, 13, 1'b0);
    add_item(16'd42,    1'b1, 0, 1'b0);
    add_item(16'd7,     1'b1, 0, 1'b0);

    // Random: spread over all digit counts, with calm stretches and drains
    for (int i = 0; i < 358; i++) begin
      case ($urandom_range(0, 4))
        0:       top = 9;
        1:       top = 99;
        2:       top = 999;
        3:       top = 9999;
        default: top = 65535;
      endcase
      gap = ((i >= 80 && i < 140) || (i >= 250 && i < 290)) ? 0 :
            $urandom_range(0, MAX_IDLE);
      add_item(b2da_pkg::VALUE_W'($urandom_range(0, top)), 1'($urandom_range(0, 1)), gap,
               i == 0 || i == 180 || i == 320);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Long receiver hold while the sender keeps offering
    while (pending.size() > 300) @(negedge clk);
    hold_requests++;
    while (pending.size() > 240) @(negedge clk);
    calm_rx = 1'b1;
    while (pending.size() > 190) @(negedge clk);
    calm_rx = 1'b0;

    while (pending.size() != 0 || in_valid) @(negedge clk);
    while (digits_due.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[binary_to_decimal_ascii.f]
+incdir+rtl
rtl/b2da_pkg.sv
rtl/b2da_dp.sv
rtl/b2da_ctrl.sv
rtl/binary_to_decimal_ascii.sv
dv/binary_to_decimal_ascii_tb.sv
